// ===== hw/rtl/iqagc_pkg.sv =====
// Package for the I/Q magnitude averaging step AGC.
// Holds the widths, register map, reset values, state and step codes and
// the structs shared by the top level and the root unit. No dependencies.
package iqagc_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = 16;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ACC_W      = 32;
  localparam int WEIGHT_W   = 16;
  localparam int PROD_W     = ACC_W + WEIGHT_W;
  localparam int GAIN_W     = 4;
  localparam int STEP_W     = 2;
  localparam int ROOT_STEPS = MAG_W;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Defaults for the top-level parameters
  localparam int DEF_AVG_STRIDE  = 4;
  localparam int DEF_INDEX_WIDTH = 48;

  // Register reset values
  localparam logic                RST_AUTO_GAIN  = 1'b1;
  localparam logic [GAIN_W-1:0]   RST_GAIN_LIMIT = 4'd6;
  localparam logic [MAG_W-1:0]    RST_LOWER_THR  = 16'd1638;
  localparam logic [MAG_W-1:0]    RST_UPPER_THR  = 16'd8192;
  localparam logic [WEIGHT_W-1:0] RST_AVG_WEIGHT = 16'd66;

  // Register indexes (byte address is four times the index)
  typedef enum logic [2:0] {
    REG_AUTO_GAIN  = 3'd0,
    REG_GAIN_LIMIT = 3'd1,
    REG_LOWER_THR  = 3'd2,
    REG_UPPER_THR  = 3'd3,
    REG_AVG_WEIGHT = 3'd4
  } cfg_reg_t;

  // Gain step reported with each word
  typedef enum logic [STEP_W-1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } gain_step_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_Q,
    ST_SUM,
    ST_ROOT,
    ST_MUL_ACC,
    ST_MUL_MAG,
    ST_UPDATE,
    ST_DECIDE
  } iqagc_state_t;

  // Root unit request and response
  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_rsp_t;

endpackage

// ===== hw/rtl/iqagc_if.sv =====
// Handshake interfaces for the sample words in and the result words out.
// Depends on iqagc_pkg for field widths.
interface iqagc_in_if
  import iqagc_pkg::*;
#(
  parameter int INDEX_W = DEF_INDEX_WIDTH
);
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] i_value;
  logic signed [SAMPLE_W-1:0] q_value;
  logic                       buffer_first;
  logic                       buffer_last;
  logic [INDEX_W-1:0]         buffer_offset;

  modport source (
    output valid, i_value, q_value, buffer_first, buffer_last, buffer_offset,
    input  ready
  );
  modport sink (
    input  valid, i_value, q_value, buffer_first, buffer_last, buffer_offset,
    output ready
  );
endinterface

interface iqagc_out_if
  import iqagc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  magnitude;
  logic [MAG_W-1:0]  running_average;
  logic [GAIN_W-1:0] gain_value;
  logic [STEP_W-1:0] gain_step;
  logic              buffer_done;

  modport source (
    output valid, magnitude, running_average, gain_value, gain_step, buffer_done,
    input  ready
  );
  modport sink (
    input  valid, magnitude, running_average, gain_value, gain_step, buffer_done,
    output ready
  );
endinterface

// ===== hw/rtl/iqagc_mul.sv =====
// Shared registered multiplier, 32 x 16 bits unsigned.
// Depends on iqagc_pkg for operand widths.
module iqagc_mul
  import iqagc_pkg::*;
(
  input  logic                clk,
  input  logic [ACC_W-1:0]    op_a,
  input  logic [WEIGHT_W-1:0] op_b,
  output logic [PROD_W-1:0]   prod_r
);

  // Register the product; the sequencer picks it up in the following state
  always_ff @(posedge clk) begin
    prod_r <= {{WEIGHT_W{1'b0}}, op_a} * {{ACC_W{1'b0}}, op_b};
  end

endmodule

// ===== hw/rtl/iqagc_sqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on iqagc_pkg for widths and the request/response structs.
module iqagc_sqrt
  import iqagc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int REM_W = MAG_W + 4;
  localparam int CNT_W = $clog2(ROOT_STEPS);

  logic [SQ_W-1:0]  x_r;
  logic [REM_W-1:0] rem_r;
  logic [MAG_W-1:0] root_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], x_r[SQ_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    fits   = (rem_sh >= trial);
  end

  // Control: busy while the ROOT_STEPS root bits are formed, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder, root and shifting radicand
  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= req.radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[SQ_W-3:0], 2'b00};
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[MAG_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = root_r;

endmodule

// ===== hw/rtl/iq_magnitude_average_step_agc.sv =====
// I/Q magnitude with exponential average and step gain control, top level.
// Depends on iqagc_pkg, iqagc_if, iqagc_mul and iqagc_sqrt.
//
//  channel   direction  handshake             payload
//  in_chan   sink       valid/ready           i_value q_value buffer_first/last/offset
//  out_chan  source     valid/ready           magnitude running_average gain_value
//                                             gain_step buffer_done
//  cfg_*     slave      psel/penable, pready  5 registers at byte address 4*index
//
// A word on an averaging slot also passes the two average products; the
// 16-step square root dominates, and a single 32x16 multiplier serves the two
// squares and the two average products in turn.
// Reset is synchronous, active low, and leaves the block ready at once.
// A full output register stalls the sequencer in its final step only; the
// next sample word is taken while a finished result waits.
module iq_magnitude_average_step_agc
  import iqagc_pkg::*;
#(
  parameter int AVG_STRIDE  = DEF_AVG_STRIDE,
  parameter int INDEX_WIDTH = DEF_INDEX_WIDTH
)(
  input  logic                  clk,
  input  logic                  rst_n,
  iqagc_in_if.sink              in_chan,
  iqagc_out_if.source           out_chan,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int PHASE_W = (AVG_STRIDE > 1) ? $clog2(AVG_STRIDE) : 1;

  // Configuration registers
  logic                auto_r;
  logic [GAIN_W-1:0]   limit_r;
  logic [MAG_W-1:0]    lower_r;
  logic [MAG_W-1:0]    upper_r;
  logic [WEIGHT_W-1:0] weight_r;

  // Block state
  iqagc_state_t           state_r, state_nxt;
  logic [GAIN_W-1:0]      gain_r;
  logic [INDEX_WIDTH-1:0] hold_r;
  logic [INDEX_WIDTH-1:0] start_r;
  logic [INDEX_WIDTH-1:0] count_r;
  logic [ACC_W-1:0]       acc_r;
  logic [PHASE_W-1:0]     phase_r;

  // Working registers for the word in flight
  logic [SAMPLE_W-1:0] i_r;
  logic [SAMPLE_W-1:0] q_r;
  logic                last_r;
  logic [SQ_W-1:0]     sq_r;
  logic [MAG_W-1:0]    mag_r;
  logic [ACC_W-1:0]    diff_r;

  // Output register
  logic              out_valid_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic [MAG_W-1:0]  out_avg_r;
  logic [GAIN_W-1:0] out_gain_r;
  gain_step_t        out_step_r;
  logic              out_done_r;

  // Shared units
  logic [ACC_W-1:0]    mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [PROD_W-1:0]   prod_r;
  sqrt_req_t           sq_req;
  sqrt_rsp_t           sq_rsp;

  // Sequencer outputs and decision terms
  logic                in_ready;
  logic                out_load;
  logic [SAMPLE_W-1:0] i_abs;
  logic [SAMPLE_W-1:0] q_abs;
  logic [ACC_W:0]      acc_sum;
  logic                judge;
  logic                step_up;
  logic                step_dn;
  logic [GAIN_W-1:0]   gain_up;
  logic [GAIN_W-1:0]   gain_fin;
  gain_step_t          step_code;
  logic                cfg_wr;

  iqagc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod_r)
  );

  iqagc_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sq_req),
    .rsp   (sq_rsp)
  );

  // Magnitudes of the components; the most negative value maps to 2^15
  assign i_abs = i_r[SAMPLE_W-1] ? (~i_r + 1'b1) : i_r;
  assign q_abs = q_r[SAMPLE_W-1] ? (~q_r + 1'b1) : q_r;

  // Average update: decayed value plus weighted magnitude, saturated
  assign acc_sum = {1'b0, diff_r} + {1'b0, prod_r[ACC_W-1:0]};

  // Gain decision on the last word of a buffer
  always_comb begin
    judge    = last_r && auto_r && (start_r > hold_r);
    step_up  = judge && (acc_r < {lower_r, 16'h0000}) && (gain_r < limit_r);
    gain_up  = step_up ? (gain_r + 1'b1) : gain_r;
    step_dn  = judge && (acc_r > {upper_r, 16'h0000}) && (gain_up != '0);
    gain_fin = step_dn ? (gain_up - 1'b1) : gain_up;
    if (step_dn) begin
      step_code = STEP_DOWN;
    end else if (step_up) begin
      step_code = STEP_UP;
    end else begin
      step_code = STEP_NONE;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, multiplier operands and unit requests
  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    out_load        = 1'b0;
    mul_a           = '0;
    mul_b           = '0;
    sq_req.start    = 1'b0;
    sq_req.radicand = sq_r + prod_r[SQ_W-1:0];
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_chan.valid) begin
          state_nxt = ST_MUL_I;
        end
      end
      ST_MUL_I: begin
        mul_a     = ACC_W'(i_abs);
        mul_b     = i_abs;
        state_nxt = ST_MUL_Q;
      end
      ST_MUL_Q: begin
        mul_a     = ACC_W'(q_abs);
        mul_b     = q_abs;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sq_req.start = 1'b1;
        state_nxt    = ST_ROOT;
      end
      ST_ROOT: begin
        if (sq_rsp.done) begin
          state_nxt = (phase_r == '0) ? ST_MUL_ACC : ST_DECIDE;
        end
      end
      ST_MUL_ACC: begin
        mul_a     = acc_r;
        mul_b     = weight_r;
        state_nxt = ST_MUL_MAG;
      end
      ST_MUL_MAG: begin
        mul_a     = ACC_W'(mag_r);
        mul_b     = weight_r;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_chan.ready = in_ready;

  // Block state: buffer start, count, average, phase, gain and hold mark
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      hold_r  <= '0;
      start_r <= '0;
      count_r <= '0;
      acc_r   <= '0;
      phase_r <= '0;
    end else begin
      if (in_ready && in_chan.valid && in_chan.buffer_first) begin
        start_r <= in_chan.buffer_offset[INDEX_WIDTH-1:0];
        count_r <= '0;
        phase_r <= '0;
        acc_r   <= '0;
      end
      if (state_r == ST_MUL_I) begin
        count_r <= count_r + 1'b1;
      end
      if (state_r == ST_UPDATE) begin
        acc_r <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
      end
      if (out_load) begin
        phase_r <= (phase_r == PHASE_W'(AVG_STRIDE - 1)) ? '0 : (phase_r + 1'b1);
        gain_r  <= gain_fin;
        if (step_up || step_dn) begin
          hold_r <= start_r + count_r;
        end
      end
    end
  end

  // Working registers for the word in flight
  always_ff @(posedge clk) begin
    if (in_ready && in_chan.valid) begin
      i_r    <= in_chan.i_value;
      q_r    <= in_chan.q_value;
      last_r <= in_chan.buffer_last;
    end
    if (state_r == ST_MUL_Q) begin
      sq_r <= prod_r[SQ_W-1:0];
    end
    if (state_r == ST_ROOT && sq_rsp.done) begin
      mag_r <= sq_rsp.root;
    end
    if (state_r == ST_MUL_MAG) begin
      diff_r <= acc_r - prod_r[PROD_W-1:WEIGHT_W];
    end
  end

  // Output register: hold the word until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mag_r  <= mag_r;
      out_avg_r  <= acc_r[ACC_W-1:ACC_W-MAG_W];
      out_gain_r <= gain_fin;
      out_step_r <= step_code;
      out_done_r <= last_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.magnitude       = out_mag_r;
  assign out_chan.running_average = out_avg_r;
  assign out_chan.gain_value      = out_gain_r;
  assign out_chan.gain_step       = out_step_r;
  assign out_chan.buffer_done     = out_done_r;

  // Register writes in the access phase
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_r   <= RST_AUTO_GAIN;
      limit_r  <= RST_GAIN_LIMIT;
      lower_r  <= RST_LOWER_THR;
      upper_r  <= RST_UPPER_THR;
      weight_r <= RST_AVG_WEIGHT;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]))
        REG_AUTO_GAIN:  auto_r   <= cfg_pwdata[0];
        REG_GAIN_LIMIT: limit_r  <= cfg_pwdata[GAIN_W-1:0];
        REG_LOWER_THR:  lower_r  <= cfg_pwdata[MAG_W-1:0];
        REG_UPPER_THR:  upper_r  <= cfg_pwdata[MAG_W-1:0];
        REG_AVG_WEIGHT: weight_r <= cfg_pwdata[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]))
      REG_AUTO_GAIN:  cfg_prdata = CFG_DATA_W'(auto_r);
      REG_GAIN_LIMIT: cfg_prdata = CFG_DATA_W'(limit_r);
      REG_LOWER_THR:  cfg_prdata = CFG_DATA_W'(lower_r);
      REG_UPPER_THR:  cfg_prdata = CFG_DATA_W'(upper_r);
      REG_AVG_WEIGHT: cfg_prdata = CFG_DATA_W'(weight_r);
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/iqagc_checker.sv =====
// Port-level checks for the I/Q magnitude step AGC, bound to the top level.
// Depends on iqagc_pkg for the gain step codes.
module iqagc_checker
  import iqagc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [GAIN_W-1:0] out_gain_value,
  input logic [STEP_W-1:0] out_gain_step,
  input logic              out_buffer_done,
  input logic              cfg_pready
);

  // Result word stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // One word at a time: the block is busy right after taking one
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  // A gain step only ever comes with the last word of a buffer
  a_step_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gain_step != STEP_NONE) |-> out_buffer_done)
    else $error("gain step reported off a buffer end");

  // A step up can never leave the gain at zero
  a_step_up_gain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_gain_step == STEP_UP) |-> (out_gain_value != '0))
    else $error("gain step up reported with zero gain");

  // Reset leaves the block empty and ready, with the register port ready
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready && cfg_pready)
    else $error("block not idle after reset");

endmodule

bind iq_magnitude_average_step_agc iqagc_checker u_iqagc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_gain_value  (out_chan.gain_value),
  .out_gain_step   (out_chan.gain_step),
  .out_buffer_done (out_chan.buffer_done),
  .cfg_pready      (cfg_pready)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the I/Q magnitude averaging step AGC.
// Needs iqagc_pkg, the iqagc_in_if/iqagc_out_if interfaces and the top level
// iq_magnitude_average_step_agc with the multiplier and root units it instantiates.
module tb
  import iqagc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDX_W       = DEF_INDEX_WIDTH;
  localparam int IDLE_PCT    = 11;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 135;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] i_value;
    logic signed [SAMPLE_W-1:0] q_value;
    logic                       first;
    logic                       last;
    logic [IDX_W-1:0]           offset;
  } sample_word_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic [MAG_W-1:0]  average;
    logic [GAIN_W-1:0] gain;
    gain_step_t        step;
    logic              done;
  } result_word_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] i_value;
    logic signed [SAMPLE_W-1:0] q_value;
    logic                       first;
    logic                       last;
    logic [IDX_W-1:0]           offset;
    bit                         typed;
    logic [MAG_W-1:0]           magnitude;
    logic [MAG_W-1:0]           average;
    logic [GAIN_W-1:0]          gain;
    gain_step_t                 step;
  } directed_row_t;

  typedef struct {
    logic                auto_on;
    logic [GAIN_W-1:0]   limit;
    logic [MAG_W-1:0]    lower;
    logic [MAG_W-1:0]    upper;
    logic [WEIGHT_W-1:0] weight;
  } agc_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  iqagc_in_if #(.INDEX_W(IDX_W)) in_chan ();
  iqagc_out_if                   out_chan ();

  iq_magnitude_average_step_agc #(
    .AVG_STRIDE (DEF_AVG_STRIDE),
    .INDEX_WIDTH(IDX_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #5 clk = ~clk;

  // Register copies and block state mirrored by the predictor
  logic                reg_auto_gain  = RST_AUTO_GAIN;
  logic [GAIN_W-1:0]   reg_gain_limit = RST_GAIN_LIMIT;
  logic [MAG_W-1:0]    reg_lower_thr  = RST_LOWER_THR;
  logic [MAG_W-1:0]    reg_upper_thr  = RST_UPPER_THR;
  logic [WEIGHT_W-1:0] reg_weight     = RST_AVG_WEIGHT;

  logic [GAIN_W-1:0] gain_now     = '0;
  logic [IDX_W-1:0]  hold_index   = '0;
  logic [IDX_W-1:0]  buffer_start = '0;
  logic [IDX_W-1:0]  buffer_count = '0;
  logic [ACC_W-1:0]  avg_acc      = '0;
  int                avg_phase    = 0;

  result_word_t due_results[$];

  bit steady       = 1'b0;
  bit hold_request = 1'b0;
  int fail_count   = 0;
  int words_sent   = 0;
  int words_seen   = 0;
  int steps_up     = 0;
  int steps_down   = 0;
  int settings_run = 0;
  int cycle_count  = 0;

  logic [IDX_W-1:0] stream_pos = '0;

  // Floor square root, one result bit per pass from the top down
  function automatic logic [MAG_W-1:0] floor_root(input logic [SQ_W-1:0] radicand);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    logic [63:0]      square;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial  = root | (MAG_W'(1) << b);
      square = 64'(trial) * 64'(trial);
      if (square <= 64'(radicand)) root = trial;
    end
    return root;
  endfunction

  // Advance the mirrored state by one sample word and return its result word
  function automatic result_word_t agc_result(input sample_word_t w);
    result_word_t res;
    longint       si;
    longint       sq;
    logic [63:0]  wide_acc;
    logic [63:0]  wide_w;
    logic [63:0]  acc_next;
    logic [MAG_W-1:0] mag;
    gain_step_t   stp;
    if (w.first) begin
      buffer_start = w.offset;
      buffer_count = '0;
      avg_phase    = 0;
      avg_acc      = '0;
    end
    si  = longint'($signed(w.i_value));
    sq  = longint'($signed(w.q_value));
    mag = floor_root(SQ_W'(si * si + sq * sq));

    // Update the average on the first slot of each stride only
    if (avg_phase == 0) begin
      wide_acc = 64'(avg_acc);
      wide_w   = 64'(reg_weight);
      acc_next = wide_acc - ((wide_acc * wide_w) >> 16) + 64'(mag) * wide_w;
      avg_acc  = (acc_next > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_next[ACC_W-1:0];
    end
    avg_phase    = (avg_phase + 1) % DEF_AVG_STRIDE;
    buffer_count = buffer_count + 1'b1;

    // Step decision on the last word of a buffer past the hold mark
    stp = STEP_NONE;
    if (w.last && reg_auto_gain && buffer_start > hold_index) begin
      if (avg_acc < {reg_lower_thr, 16'd0} && gain_now < reg_gain_limit) begin
        hold_index = buffer_start + buffer_count;
        gain_now   = gain_now + 1'b1;
        stp        = STEP_UP;
      end
      if (avg_acc > {reg_upper_thr, 16'd0} && gain_now > 0) begin
        hold_index = buffer_start + buffer_count;
        gain_now   = gain_now - 1'b1;
        stp        = STEP_DOWN;
      end
    end
    if (stp == STEP_UP) steps_up++;
    if (stp == STEP_DOWN) steps_down++;

    res.magnitude = mag;
    res.average   = avg_acc[ACC_W-1:16];
    res.gain      = gain_now;
    res.step      = stp;
    res.done      = w.last;
    return res;
  endfunction

  function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] addr,
                                          input logic [CFG_DATA_W-1:0] data);
    case (cfg_reg_t'(addr[CFG_ADDR_W-1:2]))
      REG_AUTO_GAIN:  reg_auto_gain  = data[0];
      REG_GAIN_LIMIT: reg_gain_limit = data[GAIN_W-1:0];
      REG_LOWER_THR:  reg_lower_thr  = data[MAG_W-1:0];
      REG_UPPER_THR:  reg_upper_thr  = data[MAG_W-1:0];
      REG_AVG_WEIGHT: reg_weight     = data[WEIGHT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [CFG_ADDR_W-1:0] reg_addr(input cfg_reg_t r);
    return {r, 2'b00};
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[IDX_W-1:0];
  endfunction

  // Sample value at one of four loudness levels, the loudest covering all codes
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int level);
    case (level)
      0:       return SAMPLE_W'(int'($urandom_range(64)) - 32);
      1:       return SAMPLE_W'(int'($urandom_range(6000)) - 3000);
      2:       return SAMPLE_W'(int'($urandom_range(40000)) - 20000);
      default: return SAMPLE_W'($urandom_range(65535));
    endcase
  endfunction

  // APB write: setup then access; called and left at a falling edge
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    apply_reg_write(addr, data);
    @(negedge clk);
  endtask

  task automatic cfg_idle();
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // Write every register, with junk above each field to check masking
  task automatic program_agc(input agc_setting_t s);
    write_reg(reg_addr(REG_AUTO_GAIN),  ($urandom() << 1) | 32'(s.auto_on));
    write_reg(reg_addr(REG_GAIN_LIMIT), ($urandom() << GAIN_W) | 32'(s.limit));
    write_reg(reg_addr(REG_LOWER_THR),  ($urandom() << MAG_W) | 32'(s.lower));
    write_reg(reg_addr(REG_UPPER_THR),  ($urandom() << MAG_W) | 32'(s.upper));
    write_reg(reg_addr(REG_AVG_WEIGHT), ($urandom() << WEIGHT_W) | 32'(s.weight));
    cfg_idle();
    settings_run++;
  endtask

  // Offer one word, with random idle cycles first; called and left at a falling edge
  task automatic send_word(input sample_word_t w, input bit typed,
                           input result_word_t typed_res);
    result_word_t res;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.i_value       <= w.i_value;
    in_chan.q_value       <= w.q_value;
    in_chan.buffer_first  <= w.first;
    in_chan.buffer_last   <= w.last;
    in_chan.buffer_offset <= w.offset;
    do @(posedge clk); while (!in_chan.ready);
    res = agc_result(w);
    due_results.insert(due_results.size(), typed ? typed_res : res);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every outstanding result word is back
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(negedge clk); while (due_results.size() != 0);
  endtask

  // Random buffers: mostly well-formed with random content, the rest noise
  task automatic send_buffers(input int target, input bit with_hold, input bit with_pause);
    sample_word_t w;
    int           sent;
    int           len;
    int           level;
    int           kind;
    bit           held;
    bit           paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;
    while (sent < target) begin
      kind  = $urandom_range(99);
      level = $urandom_range(3);
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 1);
      // Jump near the index wrap, or revisit offsets at or below the hold mark
      if (kind < 8)
        stream_pos = '1 - IDX_W'($urandom_range(30));
      else if (kind < 18 && stream_pos > 64)
        stream_pos = stream_pos - IDX_W'($urandom_range(64));
      for (int k = 0; k < len; k++) begin
        w.i_value = draw_sample(level);
        w.q_value = draw_sample(level);
        if (kind < 80) begin
          w.first  = (k == 0);
          w.last   = (k == len - 1);
          w.offset = (k == 0) ? stream_pos : rand_index();
        end else begin
          w.first  = ($urandom_range(3) == 0);
          w.last   = ($urandom_range(3) == 0);
          w.offset = rand_index();
        end
        send_word(w, 1'b0, '0);
      end
      stream_pos = stream_pos + IDX_W'(len);
      if ($urandom_range(3) == 0) stream_pos = stream_pos + IDX_W'($urandom_range(200));
      sent += len;
      if (with_hold && !held && sent >= target / 3) begin
        hold_request = 1'b1;
        held         = 1'b1;
      end
      if (with_pause && !paused && sent >= target / 2) begin
        drain_results();
        paused = 1'b1;
      end
    end
  endtask

  // Directed words under the reset register values
  directed_row_t directed_plan [14] = '{
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 48'd0,   1'b1, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh8000, 16'sh8000, 1'b1, 1'b0, 48'd100, 1'b1, 16'd46340, 16'd46, 4'd0, STEP_NONE},
    '{16'sh7FFF, 16'sh0000, 1'b0, 1'b0, 48'd0,   1'b1, 16'd32767, 16'd46, 4'd0, STEP_NONE},
    '{16'sh0000, 16'sh8000, 1'b0, 1'b0, 48'd0,   1'b1, 16'd32768, 16'd46, 4'd0, STEP_NONE},
    '{16'shFFFF, 16'shFFFF, 1'b0, 1'b0, 48'd0,   1'b1, 16'd1,     16'd46, 4'd0, STEP_NONE},
    '{16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0, 48'd0,   1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh8000, 16'sh0001, 1'b0, 1'b1, 48'd0,   1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh0003, 16'sh0004, 1'b1, 1'b1, 48'd50,  1'b1, 16'd5,     16'd0,  4'd1, STEP_NONE},
    '{16'sh0001, 16'sh0000, 1'b1, 1'b0, 48'd300, 1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh0000, 16'sh0000, 1'b0, 1'b1, 48'd0,   1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh7FFF, 16'sh8000, 1'b1, 1'b1, 48'd300, 1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE},
    '{16'sh1234, 16'shEDCC, 1'b0, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 16'd0, 4'd0,
      STEP_NONE},
    '{16'sh5A5A, 16'shA5A5, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF, 1'b0, 16'd0, 16'd0, 4'd0,
      STEP_NONE},
    '{16'sh0000, 16'sh0000, 1'b1, 1'b1, 48'd1,   1'b0, 16'd0,     16'd0,  4'd0, STEP_NONE}
  };

  // Register settings per random phase, extremes among them
  agc_setting_t setting_plan [9] = '{
    '{1'b1, 4'd15, 16'd20000, 16'd30000, 16'hFFFF},
    '{1'b1, 4'd15, 16'hFFFF,  16'd0,     16'd40000},
    '{1'b0, 4'd9,  16'd30000, 16'd1000,  16'd20000},
    '{1'b1, 4'd0,  16'hFFFF,  16'd0,     16'd0},
    '{1'b1, 4'd6,  16'd1638,  16'd8192,  16'd66},
    '{1'b1, 4'd10, 16'd3000,  16'd6000,  16'd8192},
    '{1'b1, 4'd0,  16'd0,     16'd0,     16'd0},
    '{1'b1, 4'd15, 16'd0,     16'hFFFF,  16'hFFFF},
    '{1'b1, 4'd15, 16'd46341, 16'd46341, 16'd1}
  };

  initial begin : stimulus
    sample_word_t  w;
    result_word_t  typed_res;
    agc_setting_t  s;
    rst_n                 <= 1'b0;
    in_chan.valid         <= 1'b0;
    in_chan.i_value       <= '0;
    in_chan.q_value       <= '0;
    in_chan.buffer_first  <= 1'b0;
    in_chan.buffer_last   <= 1'b0;
    in_chan.buffer_offset <= '0;
    cfg_psel              <= 1'b0;
    cfg_penable           <= 1'b0;
    cfg_pwrite            <= 1'b0;
    cfg_paddr             <= '0;
    cfg_pwdata            <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Walk the directed table
    foreach (directed_plan[k]) begin
      w.i_value           = directed_plan[k].i_value;
      w.q_value           = directed_plan[k].q_value;
      w.first             = directed_plan[k].first;
      w.last              = directed_plan[k].last;
      w.offset            = directed_plan[k].offset;
      typed_res.magnitude = directed_plan[k].magnitude;
      typed_res.average   = directed_plan[k].average;
      typed_res.gain      = directed_plan[k].gain;
      typed_res.step      = directed_plan[k].step;
      typed_res.done      = directed_plan[k].last;
      send_word(w, directed_plan[k].typed, typed_res);
    end
    drain_results();

    // Writes beyond the register map must change nothing
    for (int idx = 5; idx < 8; idx++) write_reg(CFG_ADDR_W'(idx * 4), $urandom());
    cfg_idle();
    stream_pos = 48'd1000;

    // Random phases, one register setting each
    foreach (setting_plan[p]) begin
      s = setting_plan[p];
      if (p == 6) begin
        s.auto_on = 1'($urandom_range(1));
        s.limit   = GAIN_W'($urandom_range(15));
        s.lower   = MAG_W'($urandom_range(65535));
        s.upper   = MAG_W'($urandom_range(65535));
        s.weight  = WEIGHT_W'($urandom_range(65535));
      end
      program_agc(s);
      steady = (p == 4);
      send_buffers(PHASE_WORDS, p == 1, p == 5);
      drain_results();
    end
    steady = 1'b0;

    // Let any stray word surface before closing
    repeat (60) @(posedge clk);
    $display("Sent %0d sample words under %0d register settings; %0d result words checked.",
             words_sent, settings_run + 1, words_seen);
    $display("Gain stepped up %0d times and down %0d times; %0d failures.",
             steps_up, steps_down, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request
  initial begin : result_sink
    int held;
    out_chan.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_chan.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
      end else begin
        out_chan.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare each result word with the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    result_word_t want;
    result_word_t got;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.magnitude = out_chan.magnitude;
      got.average   = out_chan.running_average;
      got.gain      = out_chan.gain_value;
      got.step      = gain_step_t'(out_chan.gain_step);
      got.done      = out_chan.buffer_done;
      words_seen++;
      if (due_results.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected result word %0d: magnitude %0d average %0d gain %0d",
                   words_seen, got.magnitude, got.average, got.gain);
      end else begin
        want = due_results.pop_front();
        if (got.magnitude !== want.magnitude || got.average !== want.average ||
            got.gain !== want.gain || got.step !== want.step || got.done !== want.done) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $write("word %0d mismatch (exp/got): magnitude %0d/%0d average %0d/%0d ",
                   words_seen, want.magnitude, got.magnitude, want.average, got.average);
            $display("gain %0d/%0d step %0d/%0d done %0d/%0d",
                     want.gain, got.gain, want.step, got.step, want.done, got.done);
          end
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d result words outstanding.",
               cycle_count, due_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule

// ===== sim.f =====
hw/rtl/iqagc_pkg.sv
hw/rtl/iqagc_if.sv
hw/rtl/iqagc_mul.sv
hw/rtl/iqagc_sqrt.sv
hw/rtl/iq_magnitude_average_step_agc.sv
hw/rtl/iqagc_checker.sv
tb/tb.sv
